// ===== rtl/dds_pkg.sv =====
package dds_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_NODES   = 16;
    localparam int DEF_WEIGHT_BITS = 16;

    // Node indexes on the stream are 4 bits, so a run never spans more than 16 nodes
    localparam int NODE_SLOTS = 16;
    localparam int NODE_W     = 4;
    localparam int COUNT_W    = 5;

    localparam int DIST_W     = 21;
    localparam int OUT_DIST_W = 20;
    localparam logic [DIST_W-1:0] DIST_INF = 21'h1F_FFFF;
    localparam logic [DIST_W-1:0] DIST_SAT = 21'h0F_FFFF;

    localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 5'd16;
    localparam logic [COUNT_W-1:0] NODE_COUNT_MIN = 5'd2;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_RUN   = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RLX,
        ST_RLX_LAST,
        ST_OUT_RD,
        ST_OUT_LD
    } state_t;

endpackage

// ===== rtl/dense_dijkstra_shortest_paths.sv =====
// Dense single-source shortest paths. The block holds a MAX_NODES x MAX_NODES
// matrix of edge weights in a synchronous RAM (an all-ones word marks "no edge";
// a request with tuser = 0 writes one entry, negative weights store "no edge",
// oversize weights saturate). A request with tuser = 1 runs Dijkstra from the
// given source over node_count nodes (clamped to 2..min(MAX_NODES,16)) and then
// streams one result per other node in index order with tlast on the final one;
// a source at or above the node count yields nothing. Tentative distances live
// in a 16-entry RAM whose entries read as infinity until written in the run.
// Each relaxation sweep reads one matrix row and the distance RAM one node per
// cycle and tracks the next node to settle on the fly; a run makes at most n-1
// sweeps, fewer when the reachable set runs out early. Each result is read from
// the distance RAM in ST_OUT_RD, which waits while the output register is full
// and stalled, and is loaded into the output register in ST_OUT_LD; the source
// is stepped over. A write request leaves the block idle. The last result sits
// in an output register while the next request is already taken; node_count
// must be written only while the block is idle, which the block does not enforce.
module dense_dijkstra_shortest_paths
    import dds_pkg::*;
#(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,

    // node_count write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // row[3:0], col[7:4], weight[23:8], source[27:24], zero pad
    input  logic        s_tuser,   // func

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // dest[3:0], distance[23:4], no_path[24], zero pad
    output logic        m_tlast
);

    localparam int IDX_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int MAT_DEPTH = 1 << (2 * IDX_W);
    localparam int NODE_LIM  = (MAX_NODES < NODE_SLOTS) ? MAX_NODES : NODE_SLOTS;
    localparam logic [COUNT_W-1:0] NODE_LIMIT = COUNT_W'(NODE_LIM);
    localparam logic [WEIGHT_BITS-1:0] W_MAX  = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    localparam logic [WEIGHT_BITS-1:0] W_NONE = {WEIGHT_BITS{1'b1}};

    // request fields
    logic [NODE_W-1:0] in_row, in_col, in_src;
    logic [15:0]       in_weight;
    func_t             in_func;

    assign in_row    = s_tdata[3:0];
    assign in_col    = s_tdata[7:4];
    assign in_weight = s_tdata[23:8];
    assign in_src    = s_tdata[27:24];
    assign in_func   = func_t'(s_tuser);

    // registers
    state_t                 state_reg, state_next;
    logic [COUNT_W-1:0]     node_count_reg;
    logic [NODE_W-1:0]      cnt_reg;        // sweep read pointer
    logic [NODE_W-1:0]      pidx_reg;       // node whose data is coming back
    logic                   pv_reg;         // read data valid this cycle
    logic [NODE_W-1:0]      src_reg;
    logic [NODE_W-1:0]      best_reg;       // node being relaxed
    logic [DIST_W-1:0]      bestd_reg;
    logic [NODE_W-1:0]      cand_idx_reg;   // running minimum for next settle
    logic [DIST_W-1:0]      cand_d_reg;
    logic                   cand_ok_reg;
    logic [COUNT_W-1:0]     iter_reg;
    logic [NODE_W-1:0]      d_reg;          // output pointer
    logic [NODE_SLOTS-1:0]  visited_reg;
    logic [NODE_SLOTS-1:0]  dval_reg;       // distance entry written this run

    logic                   m_valid_reg;
    logic [NODE_W-1:0]      m_dest_reg;
    logic [OUT_DIST_W-1:0]  m_dist_reg;
    logic                   m_nopath_reg;
    logic                   m_last_reg;

    // memories
    logic [WEIGHT_BITS-1:0] mat_mem [MAT_DEPTH];
    logic [DIST_W-1:0]      dist_mem [NODE_SLOTS];
    logic [WEIGHT_BITS-1:0] w_rd_reg;
    logic [DIST_W-1:0]      d_rd_reg;
    logic                   dok_rd_reg;

    // effective node count
    logic [COUNT_W-1:0] n_eff;
    always_comb begin
        n_eff = node_count_reg;
        if (n_eff < NODE_COUNT_MIN) begin
            n_eff = NODE_COUNT_MIN;
        end
        if (n_eff > NODE_LIMIT) begin
            n_eff = NODE_LIMIT;
        end
    end

    logic s_take, m_take, out_free;
    logic run_start, wr_req, wr_in_range;
    logic [WEIGHT_BITS-1:0] wr_word;

    assign s_take   = s_tvalid && s_tready;
    assign m_take   = m_valid_reg && m_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign wr_in_range = (32'(in_row) < 32'(MAX_NODES)) && (32'(in_col) < 32'(MAX_NODES));
    assign wr_req      = s_take && (in_func == FUNC_WRITE) && wr_in_range;
    assign run_start   = s_take && (in_func == FUNC_RUN) && ({1'b0, in_src} < n_eff);

    always_comb begin
        if (in_weight[15]) begin
            wr_word = W_NONE;
        end else if (32'(in_weight) > 32'(W_MAX)) begin
            wr_word = W_MAX;
        end else begin
            wr_word = WEIGHT_BITS'(in_weight);
        end
    end

    // relaxation datapath on returning read data
    logic                  p_open, w_ok, upd, cand;
    logic [32:0]           sum;
    logic [DIST_W-1:0]     nd, old_d, new_d;
    logic                  found_fin;
    logic [NODE_W-1:0]     best_fin;
    logic [DIST_W-1:0]     bestd_fin;
    logic                  more_iter;

    always_comb begin
        p_open    = pv_reg && !visited_reg[pidx_reg];
        w_ok      = (w_rd_reg <= W_MAX);
        sum       = 33'(bestd_reg) + 33'(w_rd_reg);
        nd        = (sum > 33'(DIST_SAT)) ? DIST_SAT : sum[DIST_W-1:0];
        old_d     = dok_rd_reg ? d_rd_reg : DIST_INF;
        upd       = p_open && w_ok && (nd < old_d);
        new_d     = upd ? nd : old_d;
        cand      = p_open && (new_d < cand_d_reg);
        found_fin = cand_ok_reg || cand;
        best_fin  = cand ? pidx_reg : cand_idx_reg;
        bestd_fin = cand ? new_d : cand_d_reg;
        more_iter = (iter_reg + COUNT_W'(2)) < n_eff;
    end

    logic out_is_last;
    assign out_is_last = ({1'b0, d_reg} == n_eff - COUNT_W'(1)) ||
                         (({1'b0, d_reg} == n_eff - COUNT_W'(2)) &&
                          ({1'b0, src_reg} == n_eff - COUNT_W'(1)));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (run_start) state_next = ST_RLX;
            end
            ST_RLX: begin
                if ({1'b0, cnt_reg} == n_eff - COUNT_W'(1)) state_next = ST_RLX_LAST;
            end
            ST_RLX_LAST: begin
                state_next = (more_iter && found_fin) ? ST_RLX : ST_OUT_RD;
            end
            ST_OUT_RD: begin
                if (d_reg != src_reg && out_free) state_next = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                state_next = out_is_last ? ST_IDLE : ST_OUT_RD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    logic                  rd_issue;
    logic [NODE_W-1:0]     dist_ra;
    logic                  dist_we;
    logic [NODE_W-1:0]     dist_wa;
    logic [DIST_W-1:0]     dist_wd;

    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        cfg_ready = 1'b1;
        rd_issue = (state_reg == ST_RLX);
        dist_ra  = (state_reg == ST_RLX) ? cnt_reg : d_reg;
        dist_we  = run_start || upd;
        dist_wa  = run_start ? in_src : pidx_reg;
        dist_wd  = run_start ? '0 : nd;
    end

    // memories
    always_ff @(posedge aclk) begin
        if (wr_req) begin
            mat_mem[{IDX_W'(in_row), IDX_W'(in_col)}] <= wr_word;
        end
        w_rd_reg <= mat_mem[{IDX_W'(best_reg), IDX_W'(cnt_reg)}];
    end

    always_ff @(posedge aclk) begin
        if (dist_we) begin
            dist_mem[dist_wa] <= dist_wd;
        end
        d_rd_reg   <= dist_mem[dist_ra];
        dok_rd_reg <= dval_reg[dist_ra];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            node_count_reg <= NODE_COUNT_RST;
            pv_reg         <= 1'b0;
            visited_reg    <= '0;
            dval_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            pv_reg    <= rd_issue;
            if (cfg_valid && cfg_ready) begin
                node_count_reg <= cfg_data;
            end
            if (run_start) begin
                // only the source is settled and holds a distance
                visited_reg <= NODE_SLOTS'(1) << in_src;
                dval_reg    <= NODE_SLOTS'(1) << in_src;
            end else begin
                if (upd) dval_reg[pidx_reg] <= 1'b1;
                if (state_reg == ST_RLX_LAST && more_iter && found_fin) begin
                    visited_reg[best_fin] <= 1'b1;
                end
            end
            if (state_reg == ST_OUT_LD) begin
                m_valid_reg <= 1'b1;
            end else if (m_take) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // sweep and output datapath
    always_ff @(posedge aclk) begin
        if (rd_issue) begin
            pidx_reg <= cnt_reg;
            cnt_reg  <= cnt_reg + NODE_W'(1);
        end
        if (run_start) begin
            src_reg     <= in_src;
            best_reg    <= in_src;
            bestd_reg   <= '0;
            iter_reg    <= '0;
            cnt_reg     <= '0;
            cand_ok_reg <= 1'b0;
            cand_d_reg  <= DIST_INF;
        end else if (state_reg == ST_RLX_LAST) begin
            // last candidate is folded in through best_fin / bestd_fin
            best_reg    <= best_fin;
            bestd_reg   <= bestd_fin;
            iter_reg    <= iter_reg + COUNT_W'(1);
            cnt_reg     <= '0;
            cand_ok_reg <= 1'b0;
            cand_d_reg  <= DIST_INF;
            d_reg       <= '0;
        end else if (state_reg == ST_RLX) begin
            if (cand) begin
                cand_ok_reg  <= 1'b1;
                cand_idx_reg <= pidx_reg;
                cand_d_reg   <= new_d;
            end
        end
        if (state_reg == ST_OUT_RD && d_reg == src_reg) begin
            d_reg <= d_reg + NODE_W'(1);
        end
        if (state_reg == ST_OUT_LD) begin
            m_dest_reg   <= d_reg;
            m_nopath_reg <= !dok_rd_reg || (d_rd_reg == DIST_INF);
            m_dist_reg   <= (!dok_rd_reg || (d_rd_reg == DIST_INF)) ? '0
                                                                    : d_rd_reg[OUT_DIST_W-1:0];
            m_last_reg   <= out_is_last;
            if (!out_is_last) d_reg <= d_reg + NODE_W'(1);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_nopath_reg, m_dist_reg, m_dest_reg};
    assign m_tlast  = m_last_reg;

endmodule

// ===== test/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dds_pkg::*;

    // Longest stretch with no handshake on any channel before the run is called hung.
    localparam int IDLE_LIMIT    = 5000;
    // Cycles left after the last result, so that writes and ignored runs retire
    // before node_count is touched again
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 1500;
    localparam int SHOW_LIMIT    = 10;

    typedef struct packed {
        logic [NODE_W-1:0]     dest;
        logic [OUT_DIST_W-1:0] distance;
        logic                  no_path;
        logic                  last;
    } path_result_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [4:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // row[3:0], col[7:4], weight[23:8], source[27:24], zero pad
    logic        s_tuser;   // func
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // dest[3:0], distance[23:4], no_path[24], zero pad
    logic        m_tlast;

    // Shadow of the block: weight matrix, node_count and the results still owed
    logic [15:0]        edge_word [NODE_SLOTS][NODE_SLOTS];
    logic [COUNT_W-1:0] node_count_reg;
    path_result_t       expected_paths[$];

    int fail_count;
    int idle_cycles;
    int hold_left;      // long output hold-off, set by a test, counted down by the receiver
    int stall_left;
    bit tx_gaps;
    bit rx_gaps;

    dense_dijkstra_shortest_paths u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // node_count is clamped to 2..16 by the block
    function automatic int active_nodes();
        if (node_count_reg < NODE_COUNT_MIN)
            return int'(NODE_COUNT_MIN);
        if (node_count_reg > NODE_SLOTS)
            return NODE_SLOTS;
        return int'(node_count_reg);
    endfunction

    // Any negative weight becomes the all-ones "no edge" word
    task automatic store_edge(input logic [3:0] row, input logic [3:0] col,
                              input logic [15:0] weight);
        edge_word[row][col] = weight[15] ? 16'hFFFF : weight;
    endtask

    // Array Dijkstra: lowest index wins ties, stops once nothing reachable is left
    task automatic predict_paths(input logic [3:0] src);
        logic [DIST_W-1:0] tent_dist [NODE_SLOTS];
        bit                settled [NODE_SLOTS];
        logic [DIST_W-1:0] bestd;
        logic [DIST_W:0]   cand;
        path_result_t      res;
        int                n, best, k, v, last_dest;
        bit                found;
        n = active_nodes();
        if (src >= n)
            return;
        for (v = 0; v < NODE_SLOTS; v++) begin
            tent_dist[v] = DIST_INF;
            settled[v]   = 1'b0;
        end
        tent_dist[src] = '0;
        for (k = 0; k + 1 < n; k++) begin
            found = 1'b0;
            bestd = DIST_INF;
            best  = 0;
            for (v = 0; v < n; v++) begin
                if (!settled[v] && tent_dist[v] < bestd) begin
                    bestd = tent_dist[v];
                    best  = v;
                    found = 1'b1;
                end
            end
            if (!found)
                break;
            settled[best] = 1'b1;
            for (v = 0; v < n; v++) begin
                if (settled[v] || edge_word[best][v][15])
                    continue;
                cand = {1'b0, bestd} + {6'd0, edge_word[best][v]};
                if (cand > {1'b0, DIST_SAT})
                    cand = {1'b0, DIST_SAT};
                if (cand < {1'b0, tent_dist[v]})
                    tent_dist[v] = cand[DIST_W-1:0];
            end
        end
        last_dest = (src == n - 1) ? n - 2 : n - 1;
        for (v = 0; v < n; v++) begin
            if (v == src)
                continue;
            res.dest = v[NODE_W-1:0];
            if (tent_dist[v] == DIST_INF) begin
                res.distance = '0;
                res.no_path  = 1'b1;
            end else begin
                res.distance = tent_dist[v][OUT_DIST_W-1:0];
                res.no_path  = 1'b0;
            end
            res.last = (v == last_dest);
            expected_paths.push_back(res);
        end
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Valid stays high after acceptance; callers that stop sending go through
    // wait_for_drain, which drops it.
    task automatic send_request(input func_t func, input logic [3:0] row,
                                input logic [3:0] col, input logic [15:0] weight,
                                input logic [3:0] source);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {4'b0, source, weight, col, row};
        do @(posedge aclk); while (!s_tready);
        if (func == FUNC_WRITE)
            store_edge(row, col, weight);
        else
            predict_paths(source);
    endtask

    // Unused fields carry random bits so the block is seen to ignore them
    task automatic write_edge(input int row, input int col, input logic [15:0] weight);
        send_request(FUNC_WRITE, row[3:0], col[3:0], weight, 4'($urandom));
    endtask

    task automatic run_from(input int src);
        send_request(FUNC_RUN, 4'($urandom), 4'($urandom), 16'($urandom), src[3:0]);
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (expected_paths.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Only called with the block idle
    task automatic write_node_count(input logic [4:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        node_count_reg = value;
        @(posedge aclk);
    endtask

    // none_pct: share of "no edge" writes, sets how sparse the graph gets
    function automatic logic [15:0] random_weight(input int none_pct);
        int pick;
        if ($urandom_range(0, 99) < none_pct)
            return ($urandom_range(0, 3) == 0) ? {1'b1, 15'($urandom)} : 16'hFFFF;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 16'h0000;
        if (pick == 1)
            return 16'($urandom_range(1000, 32767));
        if (pick == 2)
            return 16'h7FFF;
        return 16'($urandom_range(1, 50));
    endfunction

    // Mostly writes inside the active square and valid runs; a few runs from
    // sources past the node count, which the block must drop.
    task automatic random_mix(input int count, input int none_pct);
        int i, n, pick;
        for (i = 0; i < count; i++) begin
            n    = active_nodes();
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                if ($urandom_range(0, 4) != 0)
                    write_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                               random_weight(none_pct));
                else
                    write_edge($urandom_range(0, 15), $urandom_range(0, 15),
                               random_weight(none_pct));
            end else if (pick < 93 || n == NODE_SLOTS) begin
                run_from($urandom_range(0, n - 1));
            end else begin
                run_from($urandom_range(n, 15));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, long hold-off on request, checking
    // ------------------------------------------------------------------

    task automatic check_result();
        path_result_t want;
        path_result_t got;
        got.dest     = m_tdata[3:0];
        got.distance = m_tdata[23:4];
        got.no_path  = m_tdata[24];
        got.last     = m_tlast;
        if (expected_paths.size() == 0) begin
            fail_count++;
            if (fail_count <= SHOW_LIMIT)
                $display("%0t: result with nothing expected: dest %0d dist %0d np %0b last %0b",
                         $realtime, got.dest, got.distance, got.no_path, got.last);
            return;
        end
        want = expected_paths.pop_front();
        if (got.dest != want.dest || got.distance != want.distance ||
            got.no_path != want.no_path || got.last != want.last) begin
            fail_count++;
            if (fail_count <= SHOW_LIMIT)
                $display("%0t: mismatch exp dest %0d dist %0d np %0b last %0b,",
                         $realtime, want.dest, want.distance, want.no_path, want.last,
                         " got dest %0d dist %0d np %0b last %0b",
                         got.dest, got.distance, got.no_path, got.last);
        end
    endtask

    initial begin
        m_tready   <= 1'b0;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready)
                check_result();
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Hang detector: cycles without any handshake
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Two nodes: extreme weights, negative weights as no edge, ignored sources,
    // overwrite of an entry, extreme row/col indexes
    task automatic test_two_node_graph();
        write_node_count(5'd2);
        write_edge(0, 0, 16'h0000);
        write_edge(0, 1, 16'h7FFF);
        write_edge(1, 0, 16'hFFFF);
        write_edge(1, 1, 16'h8000);
        write_edge(15, 15, 16'h0005);
        run_from(0);
        run_from(1);
        run_from(2);
        run_from(15);
        write_edge(1, 0, 16'h0000);
        run_from(1);
        write_edge(0, 1, 16'hFFFF);
        run_from(0);
        write_edge(0, 1, 16'h2AAA);
        run_from(0);
        wait_for_drain();
    endtask

    // node_count below the minimum clamps up to 2
    task automatic test_count_clamp();
        write_node_count(5'd0);
        run_from(0);
        run_from(1);
        run_from(2);
        wait_for_drain();
        write_node_count(5'd1);
        run_from(1);
        wait_for_drain();
    endtask

    // node_count 31 clamps down to 16; the whole matrix is filled before any run
    task automatic test_full_matrix();
        int r, c;
        write_node_count(5'd31);
        for (r = 0; r < NODE_SLOTS; r++)
            for (c = 0; c < NODE_SLOTS; c++)
                write_edge(r, c, random_weight(35));
        random_mix(30, 30);
        wait_for_drain();
    endtask

    // Phases at different node counts and graph densities
    task automatic test_random_counts();
        int phase;
        logic [4:0] count;
        for (phase = 0; phase < 7; phase++) begin
            case (phase)
                0: count = 5'd2;
                1: count = 5'd16;
                2: count = 5'($urandom_range(17, 31));
                3: count = 5'($urandom_range(0, 1));
                default: count = 5'($urandom_range(2, 16));
            endcase
            write_node_count(count);
            random_mix(19, $urandom_range(10, 80));
            wait_for_drain();
        end
    endtask

    // Results held back for a long stretch while runs keep coming, so the
    // block fills up and stalls its input; then the sender waits for all of it.
    task automatic test_output_hold();
        int i;
        write_node_count(5'd16);
        hold_left = HOLD_CYCLES;
        for (i = 0; i < 5; i++)
            run_from($urandom_range(0, 15));
        wait_for_drain();
    endtask

    // Closing phase at full rate on both sides
    task automatic test_steady_stream();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        write_node_count(5'($urandom_range(8, 16)));
        random_mix(40, 30);
    endtask

    initial begin
        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= FUNC_WRITE;
        cfg_valid  <= 1'b0;
        cfg_data   <= '0;
        fail_count = 0;
        hold_left  = 0;
        tx_gaps    = 1'b1;
        rx_gaps    = 1'b1;
        node_count_reg = NODE_COUNT_RST;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_two_node_graph();
        test_count_clamp();
        test_full_matrix();
        test_random_counts();
        test_output_hold();
        test_steady_stream();

        wait_for_drain();
        repeat (40) @(posedge aclk);
        if (fail_count == 0 && expected_paths.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
